// File: design/ogru_pkg.sv
`default_nettype none
package ogru_pkg;

	// grid size defaults
	localparam int GRID_WIDTH_DEF  = 256;
	localparam int GRID_HEIGHT_DEF = 256;

	// field widths
	localparam int COORD_W   = 8;
	localparam int VAL_W     = 16;
	localparam int CNT_W     = 9;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 16;
	localparam int IN_DAT_W  = 16;
	localparam int OUT_DAT_W = 32;
	localparam int ERR_W     = 12;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MISS     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_HIT      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FLOOR    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_CEIL     = 3'd5;

	// register reset values
	localparam logic [COORD_W-1:0]      ORIGIN_X_RST = 8'd128;
	localparam logic [COORD_W-1:0]      ORIGIN_Y_RST = 8'd128;
	localparam logic signed [VAL_W-1:0] MISS_RST     = -16'sd102;
	localparam logic signed [VAL_W-1:0] HIT_RST      = 16'sd217;
	localparam logic signed [VAL_W-1:0] FLOOR_RST    = -16'sd1280;
	localparam logic signed [VAL_W-1:0] CEIL_RST     = 16'sd1280;

	// input modes
	localparam logic MODE_RAY  = 1'b0;
	localparam logic MODE_READ = 1'b1;

	// one point of the line walk
	typedef struct packed {
		logic               vld;
		logic               last;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} pt_t;

	// one access to the cell store
	typedef struct packed {
		logic vld;
		logic in_grid;
		logic hit;
		logic last;
		logic rd_only;
	} cell_req_t;

	// outcome of one access
	typedef struct packed {
		logic                    vld;
		logic                    last;
		logic                    wrote;
		logic signed [VAL_W-1:0] value;
	} cell_resp_t;

	// update settings
	typedef struct packed {
		logic signed [VAL_W-1:0] miss;
		logic signed [VAL_W-1:0] hit;
		logic signed [VAL_W-1:0] floor_val;
		logic signed [VAL_W-1:0] ceil_val;
	} upd_cfg_t;

endpackage
`default_nettype wire

// File: design/ogru_line_walker.sv
`default_nettype none
module ogru_line_walker (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [ogru_pkg::COORD_W-1:0] org_x,
	input  wire logic [ogru_pkg::COORD_W-1:0] org_y,
	input  wire logic [ogru_pkg::COORD_W-1:0] end_x,
	input  wire logic [ogru_pkg::COORD_W-1:0] end_y,
	output ogru_pkg::pt_t                     pt
);
	import ogru_pkg::*;

	logic                      busy_q;
	logic [COORD_W-1:0]        x_q, y_q, ex_q, ey_q;
	logic [COORD_W-1:0]        dx_q;
	logic signed [COORD_W:0]   dy_q;
	logic                      sx_q, sy_q;
	logic signed [ERR_W-1:0]   err_q;

	logic                      at_end;
	logic signed [ERR_W:0]     e2, dx_e, dy_e, err_nxt;
	logic                      step_x, step_y;
	logic [COORD_W-1:0]        dx_start, dy_start;

	// distances for a new line
	assign dx_start = (end_x >= org_x) ? end_x - org_x : org_x - end_x;
	assign dy_start = (end_y >= org_y) ? end_y - org_y : org_y - end_y;

	// one bresenham step
	assign at_end = (x_q == ex_q) && (y_q == ey_q);
	assign e2     = (ERR_W+1)'(err_q) <<< 1;
	assign dx_e   = (ERR_W+1)'(signed'({1'b0, dx_q}));
	assign dy_e   = (ERR_W+1)'(dy_q);
	assign step_x = (e2 >= dy_e);
	assign step_y = (e2 <= dx_e);
	assign err_nxt = (ERR_W+1)'(err_q) + (step_x ? dy_e : '0) + (step_y ? dx_e : '0);

	assign pt.vld  = busy_q;
	assign pt.last = at_end;
	assign pt.x    = x_q;
	assign pt.y    = y_q;

	// walker control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && at_end) begin
			busy_q <= 1'b0;
		end
	end

	// line state
	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= org_x;
			y_q   <= org_y;
			ex_q  <= end_x;
			ey_q  <= end_y;
			dx_q  <= dx_start;
			dy_q  <= -signed'({1'b0, dy_start});
			sx_q  <= (org_x < end_x);
			sy_q  <= (org_y < end_y);
			err_q <= ERR_W'(signed'({1'b0, dx_start})) - ERR_W'(signed'({1'b0, dy_start}));
		end else if (busy_q && !at_end) begin
			err_q <= ERR_W'(err_nxt);
			if (step_x) begin
				x_q <= sx_q ? x_q + 1'b1 : x_q - 1'b1;
			end
			if (step_y) begin
				y_q <= sy_q ? y_q + 1'b1 : y_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// File: design/ogru_cell_store.sv
`default_nettype none
module ogru_cell_store #(
	parameter int DEPTH = ogru_pkg::GRID_WIDTH_DEF * ogru_pkg::GRID_HEIGHT_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire ogru_pkg::upd_cfg_t       cfg,
	input  wire ogru_pkg::cell_req_t      req,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	output ogru_pkg::cell_resp_t          resp,
	output logic                          clearing
);
	import ogru_pkg::*;

	localparam int AW = $clog2(DEPTH);

	logic [VAL_W-1:0]        mem [DEPTH];
	logic [VAL_W-1:0]        rd_q;
	cell_req_t               req_s1;
	logic [AW-1:0]           addr_s1;
	logic                    clr_q;
	logic [AW-1:0]           clr_addr_q;

	logic signed [VAL_W:0]   sum, capped;
	logic signed [VAL_W-1:0] step, sat_val;
	logic                    wr_en;

	assign clearing = clr_q;

	// saturating add on the returned cell
	assign step   = req_s1.hit ? cfg.hit : cfg.miss;
	assign sum    = (VAL_W+1)'(signed'(rd_q)) + (VAL_W+1)'(step);
	assign capped = (sum > (VAL_W+1)'(cfg.ceil_val)) ? (VAL_W+1)'(cfg.ceil_val) : sum;
	assign sat_val = (capped < (VAL_W+1)'(cfg.floor_val)) ? cfg.floor_val : VAL_W'(capped);
	assign wr_en  = req_s1.vld && req_s1.in_grid && !req_s1.rd_only;

	assign resp.vld   = req_s1.vld;
	assign resp.last  = req_s1.last;
	assign resp.wrote = wr_en;
	assign resp.value = req_s1.rd_only ? (req_s1.in_grid ? signed'(rd_q) : '0) : sat_val;

	// cell memory: clear sweep, update write, registered read
	always_ff @(posedge clk) begin
		if (clr_q) begin
			mem[clr_addr_q] <= '0;
		end else if (wr_en) begin
			mem[addr_s1] <= sat_val;
		end
		if (req.vld && req.in_grid) begin
			rd_q <= mem[addr];
		end
		addr_s1 <= addr;
	end

	// access stage and clear sweep control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_s1     <= '0;
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else begin
			req_s1 <= req;
			if (clr_q) begin
				if (clr_addr_q == AW'(DEPTH - 1)) begin
					clr_q <= 1'b0;
				end
				clr_addr_q <= clr_addr_q + 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// File: design/occupancy_grid_ray_update.sv
// channel   | dir | signals                          | content
// s_axis    | in  | tvalid tready tdata[15:0] tuser  | endpoint or cell to read, mode
// m_axis    | out | tvalid tready tdata[31:0]        | cell value, cells updated
// cfg       | in  | cfg_we cfg_index cfg_data        | register writes, no read-back
//
// a ray of n traversed cells, n up to 256, is processed by the line walker and
// cell store doing one read-modify-write a cycle
// a read, or a ray whose endpoint lies outside the grid, is a single store access
// after reset a clearing pass zeroes all GRID_WIDTH * GRID_HEIGHT cells; no
// input transfer is taken meanwhile, register writes are
// one item is in work at a time; the next input is taken while a result waits on m_axis
`default_nettype none
module occupancy_grid_ray_update #(
	parameter int GRID_WIDTH  = ogru_pkg::GRID_WIDTH_DEF,
	parameter int GRID_HEIGHT = ogru_pkg::GRID_HEIGHT_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	input  wire logic [ogru_pkg::IN_DAT_W-1:0]  s_axis_tdata,  // cell_x, cell_y
	input  wire logic                           s_axis_tuser,  // mode
	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	output logic [ogru_pkg::OUT_DAT_W-1:0]      m_axis_tdata,  // cell_value, cells_updated
	input  wire logic                           cfg_we,
	input  wire logic [ogru_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [ogru_pkg::CFG_DAT_W-1:0] cfg_data
);
	import ogru_pkg::*;

	localparam int DEPTH = GRID_WIDTH * GRID_HEIGHT;
	localparam int AW    = $clog2(DEPTH);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_BUSY = 2'd1;
	localparam logic [1:0] ST_HOLD = 2'd2;

	logic [1:0]              state_q;
	logic [COORD_W-1:0]      sensor_x_q, sensor_y_q;
	upd_cfg_t                cfg_q;
	logic [CNT_W-1:0]        cnt_q, res_cnt_q, out_cnt_q;
	logic signed [VAL_W-1:0] res_val_q, out_val_q;
	logic                    out_vld_q;

	logic [COORD_W-1:0]      in_x, in_y;
	logic                    in_mode, accept, ep_inside, start_ray, single;
	logic                    pt_inside;
	logic [AW-1:0]           in_addr, pt_addr, st_addr;
	pt_t                     pt;
	cell_req_t               st_req;
	cell_resp_t              st_resp;
	logic                    clearing;
	logic                    out_load;

	// input fields
	assign in_x    = s_axis_tdata[COORD_W-1:0];
	assign in_y    = s_axis_tdata[2*COORD_W-1:COORD_W];
	assign in_mode = s_axis_tuser;

	assign s_axis_tready = (state_q == ST_IDLE) && !clearing;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// grid bounds and addresses
	assign ep_inside = (32'(in_x) < 32'(GRID_WIDTH)) && (32'(in_y) < 32'(GRID_HEIGHT));
	assign pt_inside = (32'(pt.x) < 32'(GRID_WIDTH)) && (32'(pt.y) < 32'(GRID_HEIGHT));
	assign in_addr   = AW'(32'(in_y) * 32'(GRID_WIDTH) + 32'(in_x));
	assign pt_addr   = AW'(32'(pt.y) * 32'(GRID_WIDTH) + 32'(pt.x));

	assign start_ray = accept && (in_mode == MODE_RAY) && ep_inside;
	assign single    = accept && !start_ray;

	// store access: a single read, or the walked points
	always_comb begin
		if (single) begin
			st_req.vld     = 1'b1;
			st_req.in_grid = ep_inside;
			st_req.hit     = 1'b0;
			st_req.last    = 1'b1;
			st_req.rd_only = 1'b1;
			st_addr        = in_addr;
		end else begin
			st_req.vld     = pt.vld;
			st_req.in_grid = pt_inside;
			st_req.hit     = pt.last;
			st_req.last    = pt.last;
			st_req.rd_only = 1'b0;
			st_addr        = pt_addr;
		end
	end

	ogru_line_walker u_walker (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_ray),
		.org_x  (sensor_x_q),
		.org_y  (sensor_y_q),
		.end_x  (in_x),
		.end_y  (in_y),
		.pt     (pt)
	);

	ogru_cell_store #(
		.DEPTH (DEPTH)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.req      (st_req),
		.addr     (st_addr),
		.resp     (st_resp),
		.clearing (clearing)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sensor_x_q      <= ORIGIN_X_RST;
			sensor_y_q      <= ORIGIN_Y_RST;
			cfg_q.miss      <= MISS_RST;
			cfg_q.hit       <= HIT_RST;
			cfg_q.floor_val <= FLOOR_RST;
			cfg_q.ceil_val  <= CEIL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ORIGIN_X: sensor_x_q      <= cfg_data[COORD_W-1:0];
				CFG_ORIGIN_Y: sensor_y_q      <= cfg_data[COORD_W-1:0];
				CFG_MISS:     cfg_q.miss      <= signed'(cfg_data);
				CFG_HIT:      cfg_q.hit       <= signed'(cfg_data);
				CFG_FLOOR:    cfg_q.floor_val <= signed'(cfg_data);
				CFG_CEIL:     cfg_q.ceil_val  <= signed'(cfg_data);
				default: ;
			endcase
		end
	end

	assign out_load = (state_q == ST_HOLD) && (!out_vld_q || m_axis_tready);

	// sequencer and update count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_BUSY;
						cnt_q   <= '0;
					end
				end
				ST_BUSY: begin
					if (st_resp.vld) begin
						cnt_q <= cnt_q + CNT_W'(st_resp.wrote);
						if (st_resp.last) begin
							state_q <= ST_HOLD;
						end
					end
				end
				ST_HOLD: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// finished result
	always_ff @(posedge clk) begin
		if (state_q == ST_BUSY && st_resp.vld && st_resp.last) begin
			res_val_q <= st_resp.value;
			res_cnt_q <= cnt_q + CNT_W'(st_resp.wrote);
		end
		if (out_load) begin
			out_val_q <= res_val_q;
			out_cnt_q <= res_cnt_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {(OUT_DAT_W-VAL_W-CNT_W)'(0), out_cnt_q, out_val_q};

endmodule
`default_nettype wire

// File: design/ogru_checker.sv
`default_nettype none
module ogru_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           s_axis_tvalid,
	input wire logic                           s_axis_tready,
	input wire logic                           m_axis_tvalid,
	input wire logic                           m_axis_tready,
	input wire logic [ogru_pkg::OUT_DAT_W-1:0] m_axis_tdata
);
	import ogru_pkg::*;

	// a waiting result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// the block works on one item at a time
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken again right after a transfer");

	// update count stays within one ray and padding stays zero
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[VAL_W+CNT_W-1:VAL_W] <= CNT_W'(256))
			&& (m_axis_tdata[OUT_DAT_W-1:VAL_W+CNT_W] == '0))
		else $error("cells updated out of range");

	// no result appears in the cycle right after an input transfer
	a_no_early_out: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
		else $error("result too early");

endmodule

bind occupancy_grid_ray_update ogru_checker u_ogru_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
